// File: design/mtep_pkg.sv
// Shared item types and result kinds for the MIDI track event packer.
package mtep_pkg;

  typedef enum logic [1:0] {
    KIND_UNIT   = 2'd0,
    KIND_EOT    = 2'd1,
    KIND_BAD_ID = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_track;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] word_low;
    logic [31:0] word_high;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } step_res_t;

endpackage

// File: design/mtep_in_reg.sv
// Input register that holds one accepted item until the parser takes it.
module mtep_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mtep_pkg::in_item_t in_item_i,
  input  logic              take_i,
  output logic              valid_o,
  output mtep_pkg::in_item_t item_o
);
  import mtep_pkg::*;

  logic     valid_q, valid_d;
  logic     accept;
  in_item_t item_q;

  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign valid_d    = accept | (valid_q & ~take_i);
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

endmodule

// File: design/mtep_parser.sv
// Track chunk parser state and the single-byte step logic.
module mtep_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  mtep_pkg::in_item_t  item_i,
  output mtep_pkg::step_res_t res_o
);
  import mtep_pkg::*;

  localparam logic [31:0] TRACK_ID         = 32'h4D54_726B;
  localparam logic [3:0]  STATUS_SYSTEM    = 4'hF;
  localparam logic [3:0]  PROGRAM_CHANGE   = 4'hC;
  localparam logic [3:0]  CHANNEL_PRESSURE = 4'hD;
  localparam logic [7:0]  META_STATUS      = 8'hFF;
  localparam logic [7:0]  SYSEX_START      = 8'hF0;
  localparam logic [7:0]  SYSEX_END        = 8'hF7;
  localparam logic [7:0]  END_OF_TRACK     = 8'h2F;
  localparam logic [2:0]  HEADER_ID_LAST   = 3'd3;
  localparam logic [2:0]  HEADER_LAST      = 3'd7;
  localparam logic [2:0]  UNIT_LAST        = 3'd7;

  typedef enum logic [2:0] {
    PH_HEADER, PH_DELTA, PH_STATUS, PH_DATA1,
    PH_DATA2, PH_META_TYPE, PH_LENGTH, PH_PAYLOAD
  } phase_e;

  phase_e      ph_q, ph_d, ph_e;
  logic [31:0] hshift_q, hshift_d, hshift_e;
  logic [2:0]  hcnt_q, hcnt_d, hcnt_e;
  logic [31:0] delta_q, delta_d, delta_e;
  logic [31:0] lenacc_q, lenacc_d, lenacc_e;
  logic [31:0] left_q, left_d, left_e;
  logic [63:0] buf_q, buf_d, buf_e;
  logic [2:0]  pos_q, pos_d, pos_e;
  logic [7:0]  rs_q, rs_d, rs_e;
  logic [7:0]  cs_q, cs_d, cs_e;
  logic [7:0]  fd_q, fd_d, fd_e;
  logic [7:0]  mt_q, mt_d, mt_e;

  logic [7:0]  b;
  logic        clr;
  logic        sys_pre, sys_post;
  logic [31:0] len, count;
  logic [63:0] nb;
  step_res_t   res;

  assign b   = item_i.data_byte;
  assign clr = item_i.new_track;

  always_comb begin
    ph_e     = clr ? PH_HEADER : ph_q;
    hshift_e = clr ? '0 : hshift_q;
    hcnt_e   = clr ? '0 : hcnt_q;
    delta_e  = clr ? '0 : delta_q;
    lenacc_e = clr ? '0 : lenacc_q;
    left_e   = clr ? '0 : left_q;
    buf_e    = clr ? '0 : buf_q;
    pos_e    = clr ? '0 : pos_q;
    rs_e     = clr ? '0 : rs_q;
    cs_e     = clr ? '0 : cs_q;
    fd_e     = clr ? '0 : fd_q;
    mt_e     = clr ? '0 : mt_q;

    ph_d     = ph_e;
    hshift_d = hshift_e;
    hcnt_d   = hcnt_e;
    delta_d  = delta_e;
    lenacc_d = lenacc_e;
    left_d   = left_e;
    buf_d    = buf_e;
    pos_d    = pos_e;
    rs_d     = rs_e;
    cs_d     = cs_e;
    fd_d     = fd_e;
    mt_d     = mt_e;

    res           = '0;
    res.item.kind = KIND_UNIT;

    sys_pre  = 1'b0;
    sys_post = 1'b0;
    len      = '0;
    count    = '0;
    nb       = buf_e;
    for (int i = 0; i < 8; i++) begin
      if (pos_e == 3'(i)) begin
        nb[8*i +: 8] = b;
      end
    end

    unique case (ph_e)
      PH_HEADER: begin
        hcnt_d = hcnt_e + 3'd1;
        if (!hcnt_e[2]) begin
          hshift_d = {hshift_e[23:0], b};
          if (hcnt_e == HEADER_ID_LAST && hshift_d != TRACK_ID) begin
            hcnt_d             = '0;
            res.emit           = 1'b1;
            res.item.kind      = KIND_BAD_ID;
            res.item.word_low  = hshift_d;
          end
        end else if (hcnt_e == HEADER_LAST) begin
          delta_d = '0;
          ph_d    = PH_DELTA;
        end
      end

      PH_DELTA: begin
        delta_d = {delta_e[24:0], b[6:0]};
        if (!b[7]) begin
          ph_d = PH_STATUS;
        end
      end

      PH_STATUS: begin
        if (!b[7]) begin
          cs_d = rs_e;
          fd_d = b;
          if (rs_e[7:4] == PROGRAM_CHANGE || rs_e[7:4] == CHANNEL_PRESSURE) begin
            res.emit           = 1'b1;
            res.item.word_low  = delta_e;
            res.item.word_high = {16'h0, b, rs_e};
            rs_d               = rs_e;
            delta_d            = '0;
            ph_d               = PH_DELTA;
          end else begin
            ph_d = PH_DATA2;
          end
        end else begin
          cs_d = b;
          if (b[7:4] != STATUS_SYSTEM) begin
            ph_d = PH_DATA1;
          end else if (b == META_STATUS) begin
            rs_d = '0;
            ph_d = PH_META_TYPE;
          end else if (b == SYSEX_START || b == SYSEX_END) begin
            rs_d               = '0;
            lenacc_d           = '0;
            ph_d               = PH_LENGTH;
            res.emit           = 1'b1;
            res.item.word_low  = delta_e;
            res.item.word_high = {24'h0, b};
          end else begin
            delta_d = '0;
            ph_d    = PH_DELTA;
          end
        end
      end

      PH_DATA1: begin
        fd_d = b;
        if (cs_e[7:4] == PROGRAM_CHANGE || cs_e[7:4] == CHANNEL_PRESSURE) begin
          res.emit           = 1'b1;
          res.item.word_low  = delta_e;
          res.item.word_high = {16'h0, b, cs_e};
          rs_d               = cs_e;
          delta_d            = '0;
          ph_d               = PH_DELTA;
        end else begin
          ph_d = PH_DATA2;
        end
      end

      PH_DATA2: begin
        res.emit           = 1'b1;
        res.item.word_low  = delta_e;
        res.item.word_high = {8'h0, b, fd_e, cs_e};
        rs_d               = cs_e;
        delta_d            = '0;
        ph_d               = PH_DELTA;
      end

      PH_META_TYPE: begin
        mt_d     = b;
        lenacc_d = '0;
        ph_d     = PH_LENGTH;
        if (b != END_OF_TRACK) begin
          res.emit           = 1'b1;
          res.item.word_low  = delta_e;
          res.item.word_high = {16'h0, b, META_STATUS};
        end
      end

      PH_LENGTH: begin
        lenacc_d = {lenacc_e[24:0], b[6:0]};
        if (!b[7]) begin
          if (cs_e == META_STATUS && mt_e == END_OF_TRACK) begin
            ph_d          = PH_HEADER;
            hshift_d      = '0;
            hcnt_d        = '0;
            delta_d       = '0;
            lenacc_d      = '0;
            left_d        = '0;
            buf_d         = '0;
            pos_d         = '0;
            rs_d          = '0;
            cs_d          = '0;
            fd_d          = '0;
            mt_d          = '0;
            res.emit      = 1'b1;
            res.item.kind = KIND_EOT;
          end else begin
            sys_pre  = (cs_e == SYSEX_START) && (lenacc_d != '0);
            len      = sys_pre ? lenacc_d + 32'd1 : lenacc_d;
            sys_post = sys_pre && (len != '0);
            count    = {3'b0, len[31:3]} + {31'b0, |len[2:0]};
            buf_d    = sys_post ? {56'h0, SYSEX_START} : '0;
            pos_d    = sys_post ? 3'd1 : 3'd0;
            left_d   = (sys_pre && !sys_post) ? '0 : lenacc_d;
            if (left_d == '0) begin
              delta_d = '0;
              ph_d    = PH_DELTA;
            end else begin
              ph_d = PH_PAYLOAD;
            end
            res.emit           = 1'b1;
            res.item.word_low  = len;
            res.item.word_high = count;
          end
        end
      end

      PH_PAYLOAD: begin
        left_d = left_e - 32'd1;
        if (pos_e == UNIT_LAST || left_d == '0) begin
          res.emit           = 1'b1;
          res.item.word_low  = nb[31:0];
          res.item.word_high = nb[63:32];
          buf_d              = '0;
          pos_d              = '0;
          if (left_d == '0) begin
            delta_d = '0;
            ph_d    = PH_DELTA;
          end
        end else begin
          buf_d = nb;
          pos_d = pos_e + 3'd1;
        end
      end
    endcase
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_HEADER;
      hshift_q <= '0;
      hcnt_q   <= '0;
      delta_q  <= '0;
      lenacc_q <= '0;
      left_q   <= '0;
      buf_q    <= '0;
      pos_q    <= '0;
      rs_q     <= '0;
      cs_q     <= '0;
      fd_q     <= '0;
      mt_q     <= '0;
    end else if (advance_i) begin
      ph_q     <= ph_d;
      hshift_q <= hshift_d;
      hcnt_q   <= hcnt_d;
      delta_q  <= delta_d;
      lenacc_q <= lenacc_d;
      left_q   <= left_d;
      buf_q    <= buf_d;
      pos_q    <= pos_d;
      rs_q     <= rs_d;
      cs_q     <= cs_d;
      fd_q     <= fd_d;
      mt_q     <= mt_d;
    end
  end

endmodule

// File: design/mtep_out_reg.sv
// Result register that holds one item for the output channel.
module mtep_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  mtep_pkg::step_res_t res_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mtep_pkg::out_item_t out_item_o
);
  import mtep_pkg::*;

  logic      valid_q, valid_d;
  logic      load;
  out_item_t item_q;

  assign ready_o     = ~valid_q | ~out_stall_i;
  assign load        = ready_o & advance_i & res_i.emit;
  assign valid_d     = ready_o ? (advance_i & res_i.emit) : valid_q;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= res_i.item;
    end
  end

endmodule

// File: design/midi_track_event_packer.sv
// Top level of the MIDI track event packer.
// Each byte passes from the input register through the parser step into the result register.
// Throughput: one byte per cycle while the output side does not stall.
// A held result stalls the input only while the output side stalls.
// Reset: asynchronous, active low; parser expects a track header, both registers empty.
module midi_track_event_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mtep_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mtep_pkg::out_item_t out_item_o
);
  import mtep_pkg::*;

  logic      held_valid;
  in_item_t  held_item;
  logic      out_ready;
  logic      advance;
  step_res_t res;

  assign advance = held_valid & out_ready;

  mtep_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .take_i     (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  mtep_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (held_item),
    .res_o     (res)
  );

  mtep_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: sim/midi_track_event_packer_test.sv
// Self-checking testbench for the MIDI track event packer.
`timescale 1ns / 1ps

module midi_track_event_packer_test;
  import mtep_pkg::*;

  localparam int          UNIT_BYTES     = 8;
  localparam int          QUIET_LIMIT    = 1000;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int          RANDOM_BYTES   = 750;
  localparam logic [31:0] TRACK_ID       = 32'h4D54_726B;
  localparam logic [7:0]  STATUS_MASK    = 8'hF0;
  localparam logic [7:0]  ST_NOTE_ON     = 8'h90;
  localparam logic [7:0]  ST_PROGRAM     = 8'hC0;
  localparam logic [7:0]  ST_PRESSURE    = 8'hD0;
  localparam logic [7:0]  ST_PITCH_BEND  = 8'hE0;
  localparam logic [7:0]  ST_SYSEX       = 8'hF0;
  localparam logic [7:0]  ST_UNDEFINED   = 8'hF4;
  localparam logic [7:0]  ST_SYSEX_CONT  = 8'hF7;
  localparam logic [7:0]  ST_META        = 8'hFF;
  localparam logic [7:0]  META_TEXT      = 8'h01;
  localparam logic [7:0]  META_TRACK_NAME = 8'h03;
  localparam logic [7:0]  META_END_TRACK = 8'h2F;

  typedef enum logic [3:0] {
    WAIT_HEADER,
    READ_DELTA,
    READ_STATUS,
    READ_DATA1,
    READ_DATA2,
    READ_META,
    READ_LENGTH,
    READ_PAYLOAD
  } parse_phase_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  out_item_t expected_units[$];
  int        error_count = 0;
  int        bytes_sent = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  bit        idling_on = 1'b1;

  parse_phase_e phase;
  logic [31:0]  id_shift;
  int           id_count;
  logic [31:0]  delta_acc;
  logic [31:0]  length_acc;
  logic [31:0]  bytes_left;
  logic [63:0]  unit_buf;
  int           unit_pos;
  logic [7:0]   running_status;
  logic [7:0]   event_status;
  logic [7:0]   first_data;
  logic [7:0]   meta_code;

  midi_track_event_packer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_parser();
    phase = WAIT_HEADER;
    id_shift = '0;
    id_count = 0;
    delta_acc = '0;
    length_acc = '0;
    bytes_left = '0;
    unit_buf = '0;
    unit_pos = 0;
    running_status = '0;
    event_status = '0;
    first_data = '0;
    meta_code = '0;
  endfunction

  function automatic void expect_result(kind_e k, logic [31:0] lo, logic [31:0] hi);
    out_item_t r;
    r.kind = k;
    r.word_low = lo;
    r.word_high = hi;
    expected_units.push_back(r);
  endfunction

  function automatic void begin_delta();
    delta_acc = '0;
    phase = READ_DELTA;
  endfunction

  function automatic void finish_channel(logic [7:0] second);
    expect_result(KIND_UNIT, delta_acc, {8'h00, second, first_data, event_status});
    running_status = event_status;
    begin_delta();
  endfunction

  function automatic void take_first_data(logic [7:0] b);
    first_data = b;
    if ((event_status & STATUS_MASK) == ST_PROGRAM ||
        (event_status & STATUS_MASK) == ST_PRESSURE) begin
      finish_channel(8'h00);
    end else begin
      phase = READ_DATA2;
    end
  endfunction

  function automatic void parse_track_byte(logic [7:0] b, logic restart);
    logic [31:0] len;
    logic [31:0] count;
    if (restart) clear_parser();
    case (phase)
      WAIT_HEADER: begin
        if (id_count < 4) begin
          id_shift = {id_shift[23:0], b};
          id_count++;
          if (id_count == 4 && id_shift != TRACK_ID) begin
            id_count = 0;
            expect_result(KIND_BAD_ID, id_shift, '0);
          end
        end else begin
          id_count++;
          if (id_count >= 8) begin
            id_count = 0;
            begin_delta();
          end
        end
      end
      READ_DELTA: begin
        delta_acc = (delta_acc << 7) + b[6:0];
        if (!b[7]) phase = READ_STATUS;
      end
      READ_STATUS: begin
        if (!b[7]) begin
          event_status = running_status;
          take_first_data(b);
        end else begin
          event_status = b;
          if ((b & STATUS_MASK) != STATUS_MASK) begin
            phase = READ_DATA1;
          end else if (b == ST_META) begin
            running_status = '0;
            phase = READ_META;
          end else if (b == ST_SYSEX || b == ST_SYSEX_CONT) begin
            running_status = '0;
            length_acc = '0;
            phase = READ_LENGTH;
            expect_result(KIND_UNIT, delta_acc, {24'h0, b});
          end else begin
            begin_delta();
          end
        end
      end
      READ_DATA1: take_first_data(b);
      READ_DATA2: finish_channel(b);
      READ_META: begin
        meta_code = b;
        length_acc = '0;
        phase = READ_LENGTH;
        if (b != META_END_TRACK) expect_result(KIND_UNIT, delta_acc, {16'h0, b, ST_META});
      end
      READ_LENGTH: begin
        length_acc = (length_acc << 7) + b[6:0];
        if (!b[7]) begin
          if (event_status == ST_META && meta_code == META_END_TRACK) begin
            clear_parser();
            expect_result(KIND_EOT, '0, '0);
          end else begin
            len = length_acc;
            if (event_status == ST_SYSEX && len != 0) len++;
            count = len / UNIT_BYTES + ((len % UNIT_BYTES) != 0);
            unit_buf = '0;
            unit_pos = 0;
            if (event_status == ST_SYSEX && len != 0) begin
              unit_buf = 64'(ST_SYSEX);
              unit_pos = 1;
              bytes_left = len - 1;
            end else begin
              bytes_left = len;
            end
            if (bytes_left == 0) begin_delta();
            else phase = READ_PAYLOAD;
            expect_result(KIND_UNIT, len, count);
          end
        end
      end
      READ_PAYLOAD: begin
        unit_buf |= 64'(b) << (8 * unit_pos);
        unit_pos++;
        bytes_left--;
        if (unit_pos >= UNIT_BYTES || bytes_left == 0) begin
          expect_result(KIND_UNIT, unit_buf[31:0], unit_buf[63:32]);
          unit_buf = '0;
          unit_pos = 0;
          if (bytes_left == 0) begin_delta();
        end
      end
      default: clear_parser();
    endcase
  endfunction

  function automatic logic [31:0] random_delta();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(128, 20000);
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  function automatic int payload_length();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(100, 200);
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic restart = 1'b0);
    in_item_t it;
    it.data_byte = value;
    it.new_track = restart;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    parse_track_byte(value, restart);
    bytes_sent++;
  endtask

  task automatic send_vlq(input logic [31:0] value);
    logic [6:0] group [5];
    int first;
    first = 4;
    for (int i = 0; i < 5; i++) group[i] = 7'(value >> (7 * (4 - i)));
    for (int i = 3; i >= 0; i--) if (group[i] != 0) first = i;
    for (int i = first; i < 5; i++) send_byte({1'(i < 4), group[i]});
  endtask

  task automatic send_data(input int n);
    repeat (n) send_byte(8'($urandom()));
  endtask

  task automatic send_header(input logic restart);
    send_byte(TRACK_ID[31:24], restart);
    send_byte(TRACK_ID[23:16]);
    send_byte(TRACK_ID[15:8]);
    send_byte(TRACK_ID[7:0]);
    send_data(4);
  endtask

  task automatic send_channel(input logic [7:0] st, input logic running);
    send_vlq(random_delta());
    if (!running) send_byte(st);
    if (running || $urandom_range(0, 9) != 0) send_byte(8'($urandom_range(0, 127)));
    else send_byte(8'($urandom()));
    if ((st & STATUS_MASK) != ST_PROGRAM && (st & STATUS_MASK) != ST_PRESSURE) begin
      send_byte(8'($urandom()));
    end
  endtask

  task automatic send_meta(input logic [7:0] code, input int n);
    send_vlq(random_delta());
    send_byte(ST_META);
    send_byte(code);
    send_vlq(n);
    send_data(n);
  endtask

  task automatic send_sysex(input logic [7:0] st, input int n);
    send_vlq(random_delta());
    send_byte(st);
    send_vlq(n);
    send_data(n);
  endtask

  task automatic send_end_track();
    send_vlq(random_delta());
    send_byte(ST_META);
    send_byte(META_END_TRACK);
    send_byte(8'h00);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_units.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_track_header();
    send_byte(8'h4D, 1'b1);
    send_byte(8'h54);
    send_byte(8'h68);
    send_byte(8'h64);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_header(1'b0);
  endtask

  task automatic test_channel_events();
    send_vlq(32'd0);
    send_byte(ST_NOTE_ON);
    send_byte(8'h3C);
    send_byte(8'h7F);
    send_vlq(32'h0FFF_FFFF);
    send_byte(8'h40);
    send_byte(8'h00);
    send_vlq(32'hFFFF_FFFF);
    send_byte(ST_PROGRAM | 8'h05);
    send_byte(8'hFF);
    send_vlq(32'd0);
    send_byte(ST_PRESSURE | 8'h03);
    send_byte(8'h80);
    send_vlq(32'd127);
    send_byte(ST_PITCH_BEND);
    send_byte(8'hFF);
    send_byte(8'h80);
  endtask

  task automatic test_system_events();
    send_meta(META_TEXT, 0);
    send_meta(META_TRACK_NAME, 9);
    send_sysex(ST_SYSEX, 7);
    send_sysex(ST_SYSEX, 0);
    send_sysex(ST_SYSEX_CONT, 3);
    send_vlq(32'd5);
    send_byte(ST_UNDEFINED);
    send_vlq(32'd0);
    send_byte(8'h12);
    send_byte(8'h34);
    send_vlq(32'd0);
    send_byte(ST_SYSEX);
    send_vlq(32'hFFFF_FFFF);
    send_end_track();
  endtask

  task automatic test_track_restart();
    send_header(1'b0);
    send_vlq(32'd0);
    send_byte(ST_META);
    send_byte(META_END_TRACK);
    send_byte(8'h04);
    send_header(1'b0);
    send_vlq(32'd0);
    send_byte(ST_NOTE_ON);
    send_byte(8'h3C);
    send_header(1'b1);
    send_channel(ST_NOTE_ON, 1'b0);
    send_end_track();
  endtask

  task automatic test_random_tracks();
    int          target;
    bit          broken;
    logic [7:0]  gen_running;
    logic [7:0]  st;
    target = bytes_sent + RANDOM_BYTES;
    broken = 1'b0;
    while (bytes_sent < target) begin
      if (bytes_sent > target - 150) idling_on = 1'b0;
      else idling_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) send_data(4);
      send_header(broken || $urandom_range(0, 9) == 0);
      broken = 1'b0;
      gen_running = '0;
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 11))
          0, 1, 2, 3, 4: begin
            if (gen_running != 0 && $urandom_range(0, 1) == 1) begin
              send_channel(gen_running, 1'b1);
            end else begin
              st = 8'($urandom_range(8'h80, 8'hEF));
              send_channel(st, 1'b0);
              gen_running = st;
            end
          end
          5, 6: begin
            st = 8'($urandom_range(0, 127));
            if (st == META_END_TRACK) st = META_TEXT;
            send_meta(st, payload_length());
            gen_running = '0;
          end
          7, 8: begin
            send_sysex(($urandom_range(0, 1) == 1) ? ST_SYSEX : ST_SYSEX_CONT, payload_length());
            gen_running = '0;
          end
          9: begin
            send_vlq(random_delta());
            st = 8'($urandom_range(8'hF1, 8'hFE));
            if (st == ST_SYSEX_CONT) st = ST_UNDEFINED;
            send_byte(st);
          end
          10: begin
            send_data($urandom_range(1, 3));
            broken = 1'b1;
          end
          default: begin
            send_header(1'b1);
            gen_running = '0;
          end
        endcase
      end
      send_end_track();
      if ($urandom_range(0, 5) == 0) wait_results_done();
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_units.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h/%0h/%0h", $time,
                 out_item_o.kind, out_item_o.word_low, out_item_o.word_high);
        error_count++;
      end else begin
        want = expected_units.pop_front();
        if (out_item_o.kind !== want.kind) begin
          $display("%0t: kind mismatch, expected %0h, actual %0h", $time,
                   want.kind, out_item_o.kind);
          error_count++;
        end
        if (out_item_o.word_low !== want.word_low) begin
          $display("%0t: word_low mismatch, expected %h, actual %h", $time,
                   want.word_low, out_item_o.word_low);
          error_count++;
        end
        if (out_item_o.word_high !== want.word_high) begin
          $display("%0t: word_high mismatch, expected %h, actual %h", $time,
                   want.word_high, out_item_o.word_high);
          error_count++;
        end
      end
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("midi_track_event_packer test failed");
    $finish;
  end

  initial begin
    clear_parser();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_track_header();
    test_channel_events();
    test_system_events();
    test_track_restart();
    wait_results_done();
    test_random_tracks();
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("midi_track_event_packer test passed");
    end else begin
      $display("midi_track_event_packer test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/mtep_pkg.sv
design/mtep_in_reg.sv
design/mtep_parser.sv
design/mtep_out_reg.sv
design/midi_track_event_packer.sv
sim/midi_track_event_packer_test.sv
